// ===== rtl/swmf_pkg.sv =====
// Shared types and constants for the sliding window median filter.
package swmf_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_LEN_RESET = 5'd2;

  typedef struct packed {
    logic lo;
    logic hi;
  } swmf_sel_t;

endpackage

// ===== rtl/swmf_cell.sv =====
// One window cell: holds a sample by age, a circulating copy and the sample's rank.
module swmf_cell #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int IDX_W        = 4,
  parameter int IDX          = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic                           step,
  input  logic                           active,
  input  logic signed [SAMPLE_WIDTH-1:0] hist_in,
  input  logic signed [SAMPLE_WIDTH-1:0] circ_in,
  input  logic signed [SAMPLE_WIDTH-1:0] bval,
  input  logic        [IDX_W-1:0]        k,
  input  logic        [IDX_W-1:0]        lo_tgt,
  input  logic        [IDX_W-1:0]        hi_tgt,
  output logic signed [SAMPLE_WIDTH-1:0] hist_out,
  output logic signed [SAMPLE_WIDTH-1:0] circ_out,
  output swmf_pkg::swmf_sel_t            sel
);

  logic signed [SAMPLE_WIDTH-1:0] hist_r;
  logic signed [SAMPLE_WIDTH-1:0] circ_r;
  logic        [IDX_W-1:0]        rank_r;
  logic                           inc;

  // ties broken by age so ranks are unique
  assign inc = (bval < hist_r) || ((bval == hist_r) && (k < IDX_W'(IDX)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (load) begin
      hist_r <= hist_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      circ_r <= hist_in;
      rank_r <= '0;
    end else if (step) begin
      circ_r <= circ_in;
      if (inc) begin
        rank_r <= rank_r + 1'b1;
      end
    end
  end

  assign hist_out = hist_r;
  assign circ_out = circ_r;
  assign sel.lo   = active && (rank_r == lo_tgt);
  assign sel.hi   = active && (rank_r == hi_tgt);

endmodule

// ===== rtl/sliding_window_median_filter.sv =====
// Sliding window median filter top level: control, cell chain and median pick.
//
// Input stream (in_*): one signed sample per transfer in in_tdata.
// Output stream (out_*): one result per input, twice the median of the
// newest N samples (sum of the two middle samples when N is even).
// cfg_wen/cfg_wdata write the window length N; 0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW. Write it only while the block is idle.
// A new sample is taken only while the block is idle, after the previous
// result has entered the output register. Each sample's rank is found by
// circulating the window once through the cell chain, one sample per cycle.
// Reset clears the window to zeros and sets N to 2.
// A stalled receiver holds the result in the output register; the next
// sample is still taken and processed, and the one after waits until the
// output register is free.
module sliding_window_median_filter #(
  parameter int MAX_WINDOW   = 16,
  parameter int SAMPLE_WIDTH = 16,
  localparam int IN_TDW      = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDW     = ((SAMPLE_WIDTH + 8) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDW-1:0]         in_tdata,   // [SAMPLE_WIDTH-1:0] sample
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDW-1:0]        out_tdata,  // [SAMPLE_WIDTH:0] median_doubled
  input  logic                      cfg_wen,
  input  logic [swmf_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int CW    = (swmf_pkg::CFG_W > LEN_W) ? swmf_pkg::CFG_W : LEN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RANK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [IDX_W-1:0]            k_r, k_nxt;
  logic [swmf_pkg::CFG_W-1:0]  cfg_len_r;
  logic [CW-1:0]               cfg_ext;
  logic [LEN_W-1:0]            eff_len;
  logic [LEN_W-1:0]            len_m1;
  logic [IDX_W-1:0]            lo_tgt, hi_tgt;
  logic                        in_xfer, load, step, out_load;
  logic signed [SAMPLE_WIDTH:0] med_r, med_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic signed [SAMPLE_WIDTH-1:0] hist_w [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] circ_w [MAX_WINDOW];
  swmf_pkg::swmf_sel_t            sel_w  [MAX_WINDOW];
  logic [MAX_WINDOW-1:0]          lo_vec, hi_vec, act_vec;
  logic signed [SAMPLE_WIDTH-1:0] lo_val, hi_val;

  // window length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r <= swmf_pkg::CFG_LEN_RESET;
    end else if (cfg_wen) begin
      cfg_len_r <= cfg_wdata;
    end
  end

  assign cfg_ext = CW'(cfg_len_r);

  always_comb begin
    priority if (cfg_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg_ext > CW'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(cfg_ext);
    end
  end

  assign len_m1 = eff_len - 1'b1;
  assign lo_tgt = IDX_W'(len_m1 >> 1);
  assign hi_tgt = IDX_W'(eff_len >> 1);

  // control
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign load      = in_xfer;
  assign step      = (state_r == ST_RANK);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_RANK;
          k_nxt     = '0;
        end
      end
      ST_RANK: begin
        k_nxt = k_r + 1'b1;
        if (LEN_W'(k_r) == len_m1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // cell chain
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] hin;
    logic signed [SAMPLE_WIDTH-1:0] cin;

    if (i == 0) begin : g_head
      assign hin = SAMPLE_WIDTH'(in_tdata[SAMPLE_WIDTH-1:0]);
    end else begin : g_body
      assign hin = hist_w[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign cin = circ_w[i];
    end else begin : g_mid
      assign cin = circ_w[i+1];
    end

    assign act_vec[i] = (eff_len > LEN_W'(i));
    assign lo_vec[i]  = sel_w[i].lo;
    assign hi_vec[i]  = sel_w[i].hi;

    swmf_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .IDX_W        (IDX_W),
      .IDX          (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (load),
      .step     (step),
      .active   (act_vec[i]),
      .hist_in  (hin),
      .circ_in  (cin),
      .bval     (circ_w[0]),
      .k        (k_r),
      .lo_tgt   (lo_tgt),
      .hi_tgt   (hi_tgt),
      .hist_out (hist_w[i]),
      .circ_out (circ_w[i]),
      .sel      (sel_w[i])
    );
  end

  // median pick
  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (lo_vec[i]) begin
        lo_val = lo_val | hist_w[i];
      end
      if (hi_vec[i]) begin
        hi_val = hi_val | hist_w[i];
      end
    end
  end

  assign med_nxt = out_load ? ({lo_val[SAMPLE_WIDTH-1], lo_val} +
                               {hi_val[SAMPLE_WIDTH-1], hi_val}) : med_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    med_r <= med_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDW'($unsigned(med_r));

  // checks
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RANK) |-> (LEN_W'(k_r) < eff_len))
    else $error("rank step counter ran past window length");

  a_lo_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> $onehot(lo_vec))
    else $error("lower middle rank not unique");

  a_hi_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> $onehot(hi_vec))
    else $error("upper middle rank not unique");

  a_accept_rank: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_RANK))
    else $error("accepted sample did not start ranking");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised without a finished ranking pass");

endmodule

// ===== tb/median_checker.sv =====
// Checker for the sliding window median filter: tracks the sample window and compares results.
module median_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [15:0]                in_tdata,   // [15:0] sample
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [23:0]                out_tdata,  // [16:0] median_doubled
  input  logic                       cfg_wen,
  input  logic [swmf_pkg::CFG_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         pending
);

  localparam int DEPTH = 16;

  logic signed [15:0]         hist [DEPTH];
  logic [3:0]                 wr_ptr;
  logic [swmf_pkg::CFG_W-1:0] win_len;
  logic signed [16:0]         due_q [8];
  logic [2:0]                 due_rd;
  logic [2:0]                 due_wr;
  int                         due_cnt;

  // twice the median of the newest win_len entries, newest at index 'newest'
  function automatic logic signed [16:0] doubled_median(input logic [3:0] newest);
    logic signed [15:0] vals [DEPTH];
    logic signed [15:0] v;
    logic signed [16:0] lo_mid;
    logic signed [16:0] hi_mid;
    logic [3:0]         idx;
    int                 n;
    int                 i;
    int                 j;
    if (win_len == 0) begin
      n = 1;
    end else if (win_len > DEPTH) begin
      n = DEPTH;
    end else begin
      n = int'(win_len);
    end
    idx = newest;
    for (i = 0; i < n; i++) begin
      v   = hist[idx];
      idx = idx - 1'b1;
      j   = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    lo_mid = vals[(n - 1) / 2];
    hi_mid = vals[n / 2];
    return lo_mid + hi_mid;
  endfunction

  always @(posedge clk) begin
    logic signed [16:0] due;
    if (!rst_n) begin
      foreach (hist[k]) hist[k] = '0;
      wr_ptr     = '0;
      win_len    = swmf_pkg::CFG_LEN_RESET;
      due_rd     = '0;
      due_wr     = '0;
      due_cnt    = 0;
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_cnt == 0) begin
          $error("median_doubled: unexpected result %0d", $signed(out_tdata[16:0]));
          fail_count++;
        end else begin
          due     = due_q[due_rd];
          due_rd  = due_rd + 1'b1;
          due_cnt--;
          if (out_tdata[16:0] !== due) begin
            $error("median_doubled mismatch: expected %0d, actual %0d",
                   due, $signed(out_tdata[16:0]));
            fail_count++;
          end
        end
      end
      if (cfg_wen) begin
        win_len = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        hist[wr_ptr]  = in_tdata;
        due_q[due_wr] = doubled_median(wr_ptr);
        due_wr        = due_wr + 1'b1;
        due_cnt++;
        wr_ptr = wr_ptr + 1'b1;
      end
    end
    pending = due_cnt;
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the sliding window median filter: clock, reset, stimulus and verdict.
module testbench;

  localparam int LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [15:0]                in_tdata = '0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [23:0]                out_tdata;
  logic                       cfg_wen = 1'b0;
  logic [swmf_pkg::CFG_W-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  logic [15:0] corner [12] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h5555,
                               16'haaaa, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff};
  logic [swmf_pkg::CFG_W-1:0] phase_len [8] = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd8,
                                                5'd2, 5'd15};

  sliding_window_median_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  median_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** sliding_window_median_filter: FAILED **");
      $finish;
    end
  end

  // receiver: random backpressure, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      out_tready <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 24);
    end
  end

  function automatic logic [15:0] rand_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) return 16'($urandom);
    if (pick < 80) return 16'(int'($urandom_range(8)) - 4);
    case ($urandom_range(3))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] s);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= s;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_length(input logic [swmf_pkg::CFG_W-1:0] len);
    in_tvalid <= 1'b0;
    wait_idle();
    cfg_wdata <= len;
    cfg_wen   <= 1'b1;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset length of two: extremes and sums of the two middles
    foreach (corner[k]) send_sample(corner[k]);

    // above max saturates to the full store, older samples and reset zeros included
    write_length(5'd17);
    send_sample(16'h8000);
    send_sample(16'h0003);
    send_sample(16'hfffd);
    send_sample(16'h7fff);

    // zero length acts as one
    write_length(5'd0);
    send_sample(16'h1234);
    send_sample(16'hedcc);
    send_sample(16'h8000);

    for (int p = 0; p < 12; p++) begin
      write_length(p < 8 ? phase_len[p] : swmf_pkg::CFG_W'($urandom_range(31)));
      repeat (55) send_sample(rand_sample());
    end

    // long receiver hold-off with the sender never pausing
    write_length(5'd16);
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (150) send_sample(rand_sample());
    no_idle  = 1'b0;

    in_tvalid <= 1'b0;
    wait_idle();
    if (fail_count == 0) begin
      $display("** sliding_window_median_filter: PASSED **");
    end else begin
      $display("** sliding_window_median_filter: FAILED **");
    end
    $finish;
  end

endmodule
